/* rtl/pfb_pkg.sv */
// Shared types and constants for the page framebuffer pixel plot block.
// Panel geometry, operation and color codes, and the plot request struct.
// No dependencies.
`default_nettype none

package pfb_pkg;

	localparam int PANEL_WIDTH  = 128;
	localparam int PANEL_HEIGHT = 64;
	localparam int BUFFER_BYTES = 1024;
	localparam int ADDR_W       = $clog2(BUFFER_BYTES);

	typedef enum logic [1:0] {
		OP_DRAW  = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		COL_BLACK  = 2'd0,
		COL_WHITE  = 2'd1,
		COL_INVERT = 2'd2,
		COL_KEEP   = 2'd3
	} color_t;

	typedef struct packed {
		logic              in_bounds;
		logic              addr_ok;
		logic [ADDR_W-1:0] addr;
		logic [2:0]        bit_sel;
	} plot_t;

endpackage

`default_nettype wire

/* rtl/pfb_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
`default_nettype none

module pfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/pfb_coord.sv */
// Bounds check, quarter-turn rotation and page byte address of one pixel.
// Depends on pfb_pkg.
`default_nettype none

module pfb_coord (
	input  wire logic [1:0]  rotation,
	input  wire logic [15:0] pixel_x,
	input  wire logic [15:0] pixel_y,
	output pfb_pkg::plot_t   plot
);

	import pfb_pkg::*;

	logic [15:0] lw;
	logic [15:0] lh;
	logic [15:0] px;
	logic [15:0] py;
	logic [31:0] addr_w;

	always_comb begin
		lw = rotation[0] ? 16'(PANEL_HEIGHT) : 16'(PANEL_WIDTH);
		lh = rotation[0] ? 16'(PANEL_WIDTH) : 16'(PANEL_HEIGHT);
		unique case (rotation)
			2'd1: begin
				px = 16'(PANEL_WIDTH - 1) - pixel_y;
				py = pixel_x;
			end
			2'd2: begin
				px = 16'(PANEL_WIDTH - 1) - pixel_x;
				py = 16'(PANEL_HEIGHT - 1) - pixel_y;
			end
			2'd3: begin
				px = pixel_y;
				py = 16'(PANEL_HEIGHT - 1) - pixel_x;
			end
			default: begin
				px = pixel_x;
				py = pixel_y;
			end
		endcase
		addr_w = {16'd0, px} + 32'(py >> 3) * 32'(PANEL_WIDTH);
		plot.in_bounds = !pixel_x[15] && !pixel_y[15] && (pixel_x < lw) && (pixel_y < lh);
		plot.addr_ok   = addr_w < 32'(BUFFER_BYTES);
		plot.addr      = addr_w[ADDR_W-1:0];
		plot.bit_sel   = py[2:0];
	end

endmodule

`default_nettype wire

/* rtl/page_framebuffer_pixel_plot.sv */
// Page-layout monochrome framebuffer: pixel draw, whole-buffer clear, byte read.
// Top level: sequencer around pfb_ram and pfb_coord. Depends on pfb_pkg.
//
// Commands are taken when start is high and busy is low. A draw, a read or an
// unused opcode holds busy through ST_LOOKUP (address), then ST_UPDATE
// (read-modify-write of the RAM word); its result appears with done as busy
// falls; a new command may be taken while that done shows. A clear walks all
// BUFFER_BYTES (1024) RAM words one word a cycle, holding busy; done follows
// the last word. After reset the same walk runs, with busy high and no done,
// before the first command is taken. Results are shown for one cycle only; the
// receiver cannot stall them. The user must write rotation through cfg_we and
// cfg_wdata only while no command is in flight; the block does not enforce it.
`default_nettype none

module page_framebuffer_pixel_plot (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_wdata,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  opcode,
	input  wire logic [15:0] pixel_x,
	input  wire logic [15:0] pixel_y,
	input  wire logic [1:0]  pixel_color,
	input  wire logic [9:0]  byte_index,
	output logic             done,
	output logic [7:0]       read_data,
	output logic             pixel_drawn
);

	import pfb_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_LOOKUP = 4'b0010,
		ST_UPDATE = 4'b0100,
		ST_SWEEP  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [1:0]        rotation_q;
	logic [ADDR_W-1:0] sweep_q;
	logic              sweep_reply_q;
	op_t               op_q;
	color_t            color_q;
	logic [15:0]       x_q;
	logic [15:0]       y_q;
	logic [9:0]        idx_q;

	plot_t             plot;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;
	logic [7:0]        mask;
	logic              idx_ok;
	logic              accept;

	pfb_coord u_coord (
		.rotation (rotation_q),
		.pixel_x  (x_q),
		.pixel_y  (y_q),
		.plot     (plot)
	);

	pfb_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_BYTES),
		.AW    (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign idx_ok = 32'(idx_q) < 32'(BUFFER_BYTES);
	assign mask   = 8'(1) << plot.bit_sel;

	always_comb begin
		ram_raddr = (op_q == OP_READ) ? ADDR_W'(idx_q) : plot.addr;
		ram_we    = 1'b0;
		ram_waddr = plot.addr;
		ram_wdata = ram_rdata;
		unique case (color_q)
			COL_BLACK:  ram_wdata = ram_rdata & ~mask;
			COL_WHITE:  ram_wdata = ram_rdata | mask;
			COL_INVERT: ram_wdata = ram_rdata ^ mask;
			COL_KEEP:   ram_wdata = ram_rdata;
		endcase
		if (state_q == ST_SWEEP) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_q;
			ram_wdata = 8'd0;
		end else if (state_q == ST_UPDATE) begin
			ram_we = (op_q == OP_DRAW) && plot.in_bounds && plot.addr_ok &&
				(color_q != COL_KEEP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= 2'd0;
		end else if (cfg_we) begin
			rotation_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(opcode);
			color_q <= color_t'(pixel_color);
			x_q     <= pixel_x;
			y_q     <= pixel_y;
			idx_q   <= byte_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_SWEEP;
			sweep_q       <= '0;
			sweep_reply_q <= 1'b0;
			done          <= 1'b0;
			read_data     <= 8'd0;
			pixel_drawn   <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (op_t'(opcode) == OP_CLEAR) begin
							state_q       <= ST_SWEEP;
							sweep_q       <= '0;
							sweep_reply_q <= 1'b1;
						end else begin
							state_q <= ST_LOOKUP;
						end
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					state_q     <= ST_IDLE;
					done        <= 1'b1;
					read_data   <= ((op_q == OP_READ) && idx_ok) ? ram_rdata : 8'd0;
					pixel_drawn <= (op_q == OP_DRAW) && plot.in_bounds;
				end
				ST_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (32'(sweep_q) == 32'(BUFFER_BYTES - 1)) begin
						state_q     <= ST_IDLE;
						done        <= sweep_reply_q;
						read_data   <= 8'd0;
						pixel_drawn <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* tb/pfb_frame_checker.sv */
`timescale 1ns / 100ps
// Checker for page_framebuffer_pixel_plot: keeps a shadow frame and rotation,
// predicts each command's reply at acceptance and compares it with done.
// Depends on pfb_pkg.

module pfb_frame_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_wdata,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [1:0]  opcode,
	input  wire logic [15:0] pixel_x,
	input  wire logic [15:0] pixel_y,
	input  wire logic [1:0]  pixel_color,
	input  wire logic [9:0]  byte_index,
	input  wire logic        done,
	input  wire logic [7:0]  read_data,
	input  wire logic        pixel_drawn,
	output int               errors,
	output int               pending
);

	import pfb_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       drawn;
	} reply_t;

	logic [7:0] shadow_frame [BUFFER_BYTES];
	logic [1:0] shadow_rot;
	reply_t     owed_replies [$];
	int         reply_count;

	initial begin
		errors = 0;
		pending = 0;
		reply_count = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch on reply %0d: %s", reply_count, msg);
		errors++;
	endtask

	function automatic reply_t plot_command(input logic [1:0] op_raw, input logic [15:0] x,
			input logic [15:0] y, input logic [1:0] col_raw, input logic [9:0] idx);
		int sx;
		int sy;
		int lw;
		int lh;
		int px;
		int py;
		int addr;
		logic [7:0] mask;
		reply_t r;
		r = '0;
		case (op_t'(op_raw))
			OP_DRAW: begin
				sx = $signed(x);
				sy = $signed(y);
				lw = shadow_rot[0] ? PANEL_HEIGHT : PANEL_WIDTH;
				lh = shadow_rot[0] ? PANEL_WIDTH : PANEL_HEIGHT;
				if (sx >= 0 && sx < lw && sy >= 0 && sy < lh) begin
					r.drawn = 1'b1;
					case (shadow_rot)
						2'd1: begin
							px = PANEL_WIDTH - 1 - sy;
							py = sx;
						end
						2'd2: begin
							px = PANEL_WIDTH - 1 - sx;
							py = PANEL_HEIGHT - 1 - sy;
						end
						2'd3: begin
							px = sy;
							py = PANEL_HEIGHT - 1 - sx;
						end
						default: begin
							px = sx;
							py = sy;
						end
					endcase
					addr = px + (py / 8) * PANEL_WIDTH;
					mask = 8'(1 << (py % 8));
					if (addr < BUFFER_BYTES) begin
						case (color_t'(col_raw))
							COL_BLACK:  shadow_frame[addr] = shadow_frame[addr] & ~mask;
							COL_WHITE:  shadow_frame[addr] = shadow_frame[addr] | mask;
							COL_INVERT: shadow_frame[addr] = shadow_frame[addr] ^ mask;
							default: ;
						endcase
					end
				end
			end
			OP_CLEAR: begin
				foreach (shadow_frame[i])
					shadow_frame[i] = '0;
			end
			OP_READ: begin
				if (idx < BUFFER_BYTES)
					r.data = shadow_frame[idx];
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t got;
		reply_t want;
		if (!arst_n) begin
			foreach (shadow_frame[i])
				shadow_frame[i] = '0;
			shadow_rot = '0;
			owed_replies.delete();
			pending <= 0;
		end else begin
			if (done) begin
				got = {read_data, pixel_drawn};
				if (owed_replies.size() == 0) begin
					report_mismatch("reply with no command waiting");
				end else begin
					want = owed_replies.pop_front();
					if (got.data !== want.data)
						report_mismatch($sformatf("read_data got %0h want %0h",
							got.data, want.data));
					if (got.drawn !== want.drawn)
						report_mismatch($sformatf("pixel_drawn got %0b want %0b",
							got.drawn, want.drawn));
				end
				reply_count++;
			end
			if (cfg_we)
				shadow_rot = cfg_wdata;
			if (start && !busy)
				owed_replies.push_back(plot_command(opcode, pixel_x, pixel_y,
					pixel_color, byte_index));
			pending <= owed_replies.size();
		end
	end

endmodule

/* tb/tb_page_framebuffer_pixel_plot.sv */
`timescale 1ns / 100ps
// Testbench top for page_framebuffer_pixel_plot: directed and random commands
// over all rotations, with random idle gaps. Depends on pfb_pkg, the block and
// pfb_frame_checker.

module tb_page_framebuffer_pixel_plot;
	import pfb_pkg::*;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        cfg_we      = 1'b0;
	logic [1:0]  cfg_wdata   = '0;
	logic        start       = 1'b0;
	logic [1:0]  opcode      = '0;
	logic [15:0] pixel_x     = '0;
	logic [15:0] pixel_y     = '0;
	logic [1:0]  pixel_color = '0;
	logic [9:0]  byte_index  = '0;
	logic        busy;
	logic        done;
	logic [7:0]  read_data;
	logic        pixel_drawn;
	int          errors;
	int          pending;

	logic [1:0]  rot_now = '0;
	bit          quiet   = 1'b0;
	int          clears  = 0;

	page_framebuffer_pixel_plot dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_color(pixel_color),
		.byte_index (byte_index),
		.done       (done),
		.read_data  (read_data),
		.pixel_drawn(pixel_drawn)
	);

	pfb_frame_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_color(pixel_color),
		.byte_index (byte_index),
		.done       (done),
		.read_data  (read_data),
		.pixel_drawn(pixel_drawn),
		.errors     (errors),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(4_000_000);
		$display("FAIL page_framebuffer_pixel_plot");
		$finish;
	end

	task automatic issue(input op_t op, input logic [15:0] x, input logic [15:0] y,
			input color_t col, input logic [9:0] idx);
		while (!quiet && $urandom_range(99) < 26) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		opcode      <= op;
		pixel_x     <= x;
		pixel_y     <= y;
		pixel_color <= col;
		byte_index  <= idx;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic drain_words();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0 || busy);
	endtask

	task automatic write_rotation(input logic [1:0] value);
		drain_words();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		rot_now   = value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		logic [1:0] phase_rot [5];
		int lw;
		int lh;
		int pick;
		int kind;
		int col;
		int page;
		logic [15:0] x;
		logic [15:0] y;
		logic [9:0] idx;

		phase_rot = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd0};
		phase_rot[4] = 2'($urandom_range(3));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		issue(OP_READ, 16'd0, 16'd0, COL_BLACK, 10'd0);
		issue(OP_DRAW, 16'd0, 16'd0, COL_WHITE, 10'd0);
		issue(OP_DRAW, 16'd127, 16'd63, COL_WHITE, 10'd0);
		issue(OP_READ, 16'd0, 16'd0, COL_BLACK, 10'd0);
		issue(OP_READ, 16'd0, 16'd0, COL_BLACK, 10'd1023);
		issue(OP_DRAW, 16'hFFFF, 16'd0, COL_WHITE, 10'd0);
		issue(OP_DRAW, 16'd0, 16'hFFFF, COL_WHITE, 10'd0);
		issue(OP_DRAW, 16'd128, 16'd0, COL_WHITE, 10'd0);
		issue(OP_DRAW, 16'd0, 16'd64, COL_WHITE, 10'd0);
		issue(OP_DRAW, 16'h8000, 16'h7FFF, COL_WHITE, 10'd0);
		issue(OP_DRAW, 16'h7FFF, 16'h8000, COL_INVERT, 10'd0);
		issue(OP_DRAW, 16'd5, 16'd3, COL_KEEP, 10'd0);
		issue(OP_DRAW, 16'd5, 16'd3, COL_INVERT, 10'd0);
		issue(OP_READ, 16'd0, 16'd0, COL_BLACK, 10'd5);
		issue(OP_DRAW, 16'd5, 16'd3, COL_INVERT, 10'd0);
		issue(OP_DRAW, 16'd0, 16'd0, COL_BLACK, 10'd0);
		issue(OP_READ, 16'd0, 16'd0, COL_BLACK, 10'd5);
		issue(OP_READ, 16'd0, 16'd0, COL_BLACK, 10'd0);
		issue(OP_NONE, 16'd0, 16'd0, COL_WHITE, 10'd0);
		issue(OP_READ, 16'd0, 16'd0, COL_BLACK, 10'd0);
		issue(OP_DRAW, 16'd127, 16'd63, COL_INVERT, 10'd1023);
		issue(OP_DRAW, 16'd3, 16'd9, COL_WHITE, 10'd0);
		issue(OP_CLEAR, 16'hFFFF, 16'hFFFF, COL_KEEP, 10'h3FF);
		issue(OP_READ, 16'd0, 16'd0, COL_BLACK, 10'd131);
		issue(OP_READ, 16'd0, 16'd0, COL_BLACK, 10'd1023);

		foreach (phase_rot[p]) begin
			write_rotation(phase_rot[p]);
			quiet = (p == 2);
			lw = rot_now[0] ? PANEL_HEIGHT : PANEL_WIDTH;
			lh = rot_now[0] ? PANEL_WIDTH : PANEL_HEIGHT;
			repeat (100) begin
				pick = $urandom_range(99);
				x    = 16'($urandom());
				y    = 16'($urandom());
				idx  = 10'($urandom());
				if (pick < 58) begin
					kind = $urandom_range(99);
					if (kind < 60) begin
						x = $urandom_range(1) ? 16'($urandom_range(7))
							: 16'(lw - 1 - $urandom_range(7));
						y = $urandom_range(1) ? 16'($urandom_range(7))
							: 16'(lh - 1 - $urandom_range(7));
					end else if (kind < 85) begin
						x = 16'($urandom_range(lw - 1));
						y = 16'($urandom_range(lh - 1));
					end else if (kind < 95) begin
						x = 16'(int'($urandom_range(lw + 1)) - 1);
						y = 16'(int'($urandom_range(lh + 1)) - 1);
					end
					issue(OP_DRAW, x, y, color_t'($urandom_range(3)), idx);
				end else if (pick < 92 || (pick >= 96 && clears >= 24)) begin
					if ($urandom_range(99) < 70) begin
						col  = $urandom_range(1) ? $urandom_range(7)
							: PANEL_WIDTH - 8 + $urandom_range(7);
						page = $urandom_range(1) ? 0 : PANEL_HEIGHT / 8 - 1;
						idx  = 10'(col + page * PANEL_WIDTH);
					end
					issue(OP_READ, x, y, color_t'($urandom_range(3)), idx);
				end else if (pick < 96) begin
					issue(OP_NONE, x, y, color_t'($urandom_range(3)), idx);
				end else begin
					clears++;
					issue(OP_CLEAR, x, y, color_t'($urandom_range(3)), idx);
				end
			end
		end

		drain_words();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("PASS page_framebuffer_pixel_plot");
		else
			$display("FAIL page_framebuffer_pixel_plot");
		$finish;
	end

endmodule
